// ----- hdl/dda_line_rasterizer_macros.svh -----
// Assertion macros shared by the DDA line rasteriser RTL.
// Each macro samples on clock and is switched off while reset is high.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define DDA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/dda_pkg.sv -----
// Shared types and constants for the DDA line rasteriser.
// Used by dda_divider and dda_line_rasterizer; depends on nothing.
package dda_pkg;

   // Field widths
   localparam int COORD_W   = 6;
   localparam int DIM_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int ADDR_W    = 12;
   localparam int MAX_DIM   = 64;

   // Fixed-point format: signed Q7.FRAC_BITS
   localparam int FRAC_BITS = 16;
   localparam int ACC_W     = FRAC_BITS + 8;

   // Shared divider: dividend is |d| << FRAC_BITS, quotient is at most 1 << FRAC_BITS
   localparam int NUM_W     = COORD_W + FRAC_BITS;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 2'd2;

   localparam logic [DIM_W-1:0]  COLUMNS_RESET    = 7'd50;
   localparam logic [DIM_W-1:0]  ROWS_RESET       = 7'd10;
   localparam logic [CHAR_W-1:0] FOREGROUND_RESET = 8'd111;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } req_word_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  address;
      logic [CHAR_W-1:0]  pixel_value;
      logic               off_canvas;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   dividend;
      logic [COORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- hdl/dda_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dda_pkg for widths and the request/response structs.
module dda_divider
   import dda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [COORD_W-1:0]   rem_ff;
   logic [NUM_W-1:0]     work_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [COORD_W:0]     rem_shift;
   logic [COORD_W:0]     rem_diff;
   logic                 q_bit;

   // Shift in the next dividend bit and trial-subtract the divisor
   always_comb begin
      rem_shift = {rem_ff, work_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, div_req.divisor};
      q_bit     = (rem_shift >= {1'b0, div_req.divisor});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff   <= '0;
            work_ff  <= div_req.dividend;
            count_ff <= DIV_CNT_W'(NUM_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= q_bit ? rem_diff[COORD_W-1:0] : rem_shift[COORD_W-1:0];
            work_ff  <= {work_ff[NUM_W-2:0], q_bit};
            count_ff <= count_ff - 1'b1;
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff[QUO_W-1:0];

endmodule

// ----- hdl/dda_line_rasterizer.sv -----
// Top level of the DDA line rasteriser: sequencer, accumulators and output register.
// Depends on dda_pkg, dda_divider and dda_line_rasterizer_macros.svh.
//
//   Port group | Direction | Word / contents
//   req_*      | in        | req_word_type: start_x, start_y, end_x, end_y
//   rsp_*      | out       | rsp_word_type: one pixel write per word
//   csr_*      | in        | write enable, 2-bit register index, 8-bit data
//
// A segment with n = max(|dx|,|dy|) > 0 makes two passes through the shared
// bit-serial divider, then walks at one pixel word per cycle while rsp_stall is low.
// A zero-length segment skips the divider and goes straight to the walk.
// req_stall is high from acceptance until the last pixel is in the output register.
// rsp_stall holds the output register and pauses the walk; reset is synchronous.
module dda_line_rasterizer
   import dda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "dda_line_rasterizer_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_WALK
   } state_type;

   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   state_type            state_ff;
   logic [ACC_W-1:0]     x_acc_ff;
   logic [ACC_W-1:0]     y_acc_ff;
   logic [ACC_W-1:0]     x_step_ff;
   logic [ACC_W-1:0]     y_step_ff;
   logic [COORD_W-1:0]   steps_left_ff;
   logic                 dx_neg_ff;
   logic                 dy_neg_ff;
   logic [COORD_W-1:0]   ady_ff;
   logic [COORD_W-1:0]   n_ff;
   logic                 div_start_ff;
   logic [NUM_W-1:0]     div_dividend_ff;
   logic [DIM_W-1:0]     cols_ff;
   logic [DIM_W-1:0]     rows_ff;
   logic [CHAR_W-1:0]    fg_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_data_ff;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic                 req_accept;
   logic                 rsp_free;
   logic [COORD_W:0]     dx;
   logic [COORD_W:0]     dy;
   logic [COORD_W-1:0]   adx;
   logic [COORD_W-1:0]   ady;
   logic [COORD_W-1:0]   n_in;
   logic [ACC_W-1:0]     step_mag;
   logic [ACC_W-1:0]     x_round;
   logic [ACC_W-1:0]     y_round;
   logic [COORD_W-1:0]   px;
   logic [COORD_W-1:0]   py;
   logic [DIM_W-1:0]     cols_sat;
   logic [DIM_W-1:0]     rows_sat;
   logic [DIM_W-1:0]     row_from_top;
   logic [2*DIM_W-1:0]   row_offset;
   logic                 off;
   rsp_word_type         pixel;

   // Shared divider
   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_dividend_ff;
   assign div_req.divisor  = n_ff;

   dda_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Segment deltas and step count
   always_comb begin
      dx   = {1'b0, req_data.end_x} - {1'b0, req_data.start_x};
      dy   = {1'b0, req_data.end_y} - {1'b0, req_data.start_y};
      adx  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      n_in = (adx > ady) ? adx : ady;
   end

   // Quotient widened to the accumulator format
   assign step_mag = ACC_W'(div_rsp.quotient);

   // Round, clip and address the current pixel
   always_comb begin
      x_round  = x_acc_ff + HALF;
      y_round  = y_acc_ff + HALF;
      px       = x_round[FRAC_BITS +: COORD_W];
      py       = y_round[FRAC_BITS +: COORD_W];
      cols_sat = (cols_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_ff;
      rows_sat = (rows_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_ff;
      off      = ({1'b0, px} >= cols_sat) || ({1'b0, py} >= rows_sat);
      row_from_top = rows_sat - DIM_W'(1) - {1'b0, py};
      row_offset   = row_from_top * cols_sat;
      pixel.pixel_x     = px;
      pixel.pixel_y     = py;
      pixel.address     = off ? '0 : (ADDR_W'(row_offset) + ADDR_W'(px));
      pixel.pixel_value = fg_ff;
      pixel.off_canvas  = off;
      pixel.last        = (steps_left_ff == '0);
   end

   // Sequencer, accumulators, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         steps_left_ff <= '0;
         cols_ff       <= COLUMNS_RESET;
         rows_ff       <= ROWS_RESET;
         fg_ff         <= FOREGROUND_RESET;
      end else begin
         div_start_ff <= 1'b0;

         // Raise valid when the walk loads a word, drop it once taken
         if ((state_ff == ST_WALK) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_en) begin
            unique case (csr_index)
               CSR_COLUMNS:    cols_ff <= csr_data[DIM_W-1:0];
               CSR_ROWS:       rows_ff <= csr_data[DIM_W-1:0];
               CSR_FOREGROUND: fg_ff   <= csr_data;
               default:        ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  x_acc_ff        <= {2'b00, req_data.start_x, {FRAC_BITS{1'b0}}};
                  y_acc_ff        <= {2'b00, req_data.start_y, {FRAC_BITS{1'b0}}};
                  steps_left_ff   <= n_in;
                  n_ff            <= n_in;
                  dx_neg_ff       <= dx[COORD_W];
                  dy_neg_ff       <= dy[COORD_W];
                  ady_ff          <= ady;
                  div_dividend_ff <= {adx, {FRAC_BITS{1'b0}}};
                  if (n_in == '0) begin
                     x_step_ff <= '0;
                     y_step_ff <= '0;
                     state_ff  <= ST_WALK;
                  end else begin
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIV_X;
                  end
               end
            end
            ST_DIV_X: begin
               if (div_rsp.done) begin
                  x_step_ff       <= dx_neg_ff ? -step_mag : step_mag;
                  div_dividend_ff <= {ady_ff, {FRAC_BITS{1'b0}}};
                  div_start_ff    <= 1'b1;
                  state_ff        <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_rsp.done) begin
                  y_step_ff <= dy_neg_ff ? -step_mag : step_mag;
                  state_ff  <= ST_WALK;
               end
            end
            ST_WALK: begin
               // Emit one pixel when the output register is free, then advance or, after the last, go idle
               if (rsp_free) begin
                  rsp_data_ff <= pixel;
                  if (steps_left_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     x_acc_ff      <= x_acc_ff + x_step_ff;
                     y_acc_ff      <= y_acc_ff + y_step_ff;
                     steps_left_ff <= steps_left_ff - 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DDA_ASSERT_NEXT(a_accept_leaves_idle, req_accept, state_ff != ST_IDLE, "segment not started")
   `DDA_ASSERT_NOW(a_div_done_phase, div_rsp.done, state_ff == ST_DIV_X || state_ff == ST_DIV_Y, "stray done")
   `DDA_ASSERT_NOW(a_more_pixels, rsp_valid && !rsp_stall && !rsp_data.last, state_ff == ST_WALK, "walk ended early")

endmodule

// ----- bench/tb_dda_line_rasterizer.sv -----
// Self-checking bench for dda_line_rasterizer: directed segments, then random ones
// under several canvas settings, with burst/gap sending and random, patterned and long rsp stalls.
// Depends on dda_pkg and the dda_line_rasterizer RTL; reads no files.
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
   import dda_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int END_PAUSE   = 64;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_style_type;

   typedef struct {
      req_word_type seg;
      bit           typed;
      rsp_word_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the canvas registers
   logic [DIM_W-1:0]  cfg_columns    = COLUMNS_RESET;
   logic [DIM_W-1:0]  cfg_rows       = ROWS_RESET;
   logic [CHAR_W-1:0] cfg_foreground = FOREGROUND_RESET;

   rsp_word_type     pending_pixels[$];
   rsp_word_type     expected_pixel;
   directed_row_type directed_rows[$];

   stall_style_type stall_style = STALL_RANDOM;
   bit           long_hold_req = 1'b0;
   int           hold_left = 0;
   int           pattern_phase = 0;
   int           quiet_cycles = 0;
   int           mismatch_count = 0;
   int           segments_sent = 0;
   int           pixels_checked = 0;
   int           settings_applied = 0;

   dda_line_rasterizer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #4 clock = ~clock;

   // Round a Q7.FRAC_BITS value to the nearest pixel, half away from zero
   function automatic int round_to_pixel(int q);
      int half;
      half = 1 << (FRAC_BITS - 1);
      if (q >= 0) return (q + half) >>> FRAC_BITS;
      return -((-q + half) >>> FRAC_BITS);
   endfunction

   // Walk one segment and queue every pixel word it should produce
   task automatic trace_segment(input req_word_type seg);
      int dx, dy, span, cols, rows, x_acc, y_acc, x_step, y_step, px, py;
      bit off;
      rsp_word_type pix;
      dx   = int'(seg.end_x) - int'(seg.start_x);
      dy   = int'(seg.end_y) - int'(seg.start_y);
      span = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                        : (dy < 0 ? -dy : dy);
      cols = cfg_columns > MAX_DIM ? MAX_DIM : int'(cfg_columns);
      rows = cfg_rows > MAX_DIM ? MAX_DIM : int'(cfg_rows);
      x_acc  = int'(seg.start_x) * (1 << FRAC_BITS);
      y_acc  = int'(seg.start_y) * (1 << FRAC_BITS);
      x_step = span > 0 ? (dx * (1 << FRAC_BITS)) / span : 0;
      y_step = span > 0 ? (dy * (1 << FRAC_BITS)) / span : 0;
      for (int left = span; left >= 0; left--) begin
         px  = round_to_pixel(x_acc);
         py  = round_to_pixel(y_acc);
         off = px < 0 || py < 0 || px >= cols || py >= rows;
         pix.pixel_x     = px[COORD_W-1:0];
         pix.pixel_y     = py[COORD_W-1:0];
         pix.address     = off ? '0 : ADDR_W'(px + (rows - 1 - py) * cols);
         pix.pixel_value = cfg_foreground;
         pix.off_canvas  = off;
         pix.last        = (left == 0);
         pending_pixels.push_back(pix);
         x_acc += x_step;
         y_acc += y_step;
      end
   endtask

   function automatic directed_row_type walk(int x0, int y0, int x1, int y1);
      directed_row_type row;
      row.seg   = '{COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1)};
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   // Zero-length segment on the reset canvas: one word, known by eye
   function automatic directed_row_type dot(int x, int y, int addr, bit off);
      directed_row_type row;
      row = walk(x, y, x, y);
      row.typed            = 1'b1;
      row.want.pixel_x     = COORD_W'(x);
      row.want.pixel_y     = COORD_W'(y);
      row.want.address     = ADDR_W'(addr);
      row.want.pixel_value = FOREGROUND_RESET;
      row.want.off_canvas  = off;
      row.want.last        = 1'b1;
      return row;
   endfunction

   function automatic logic [COORD_W-1:0] clip_coord(int v);
      if (v < 0) return '0;
      if (v > 63) return '1;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] near_edge(int lim);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return clip_coord(lim - 1);
         2: return clip_coord(lim);
         default: return '1;
      endcase
   endfunction

   // Mix of full-range, short, degenerate, axis, diagonal and edge-hugging segments
   function automatic req_word_type random_segment();
      req_word_type seg;
      int len;
      seg.start_x = COORD_W'($urandom_range(0, 63));
      seg.start_y = COORD_W'($urandom_range(0, 63));
      seg.end_x   = COORD_W'($urandom_range(0, 63));
      seg.end_y   = COORD_W'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
         4, 5: begin
            seg.end_x = clip_coord(int'(seg.start_x) + int'($urandom_range(0, 8)) - 4);
            seg.end_y = clip_coord(int'(seg.start_y) + int'($urandom_range(0, 8)) - 4);
         end
         6: begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
         end
         7: begin
            if ($urandom_range(0, 1)) seg.end_y = seg.start_y;
            else seg.end_x = seg.start_x;
         end
         8: begin
            len = $urandom_range(0, 63);
            seg.end_x = clip_coord(int'(seg.start_x) + ($urandom_range(0, 1) ? len : -len));
            seg.end_y = clip_coord(int'(seg.start_y) + ($urandom_range(0, 1) ? len : -len));
         end
         9: begin
            seg.start_x = near_edge(int'(cfg_columns));
            seg.end_x   = near_edge(int'(cfg_columns));
            seg.start_y = near_edge(int'(cfg_rows));
            seg.end_y   = near_edge(int'(cfg_rows));
         end
         default: ;
      endcase
      return seg;
   endfunction

   // Offer one word and hold it until taken; valid stays high for the caller
   task automatic offer_segment(input req_word_type seg, input bit typed,
                                input rsp_word_type want);
      req_valid <= 1'b1;
      req_data  <= seg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) pending_pixels.push_back(want);
      else trace_segment(seg);
      segments_sent++;
   endtask

   task automatic rest_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding pixel word
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Write all three registers, then poke the unused index, which must be ignored
   task automatic apply_settings(input logic [7:0] cols, input logic [7:0] rows,
                                 input logic [7:0] fg);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_COLUMNS;
      csr_data     <= cols;
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_data  <= rows;
      @(posedge clock);
      csr_index <= CSR_FOREGROUND;
      csr_data  <= fg;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_data  <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_columns    = cols[DIM_W-1:0];
      cfg_rows       = rows[DIM_W-1:0];
      cfg_foreground = fg;
      settings_applied++;
   endtask

   // Random segments; bursty sending when asked, long rsp hold after hold_at words
   task automatic run_segments(input int count, input stall_style_type style,
                               input bit bursty, input int hold_at);
      int burst_left;
      burst_left  = $urandom_range(1, 8);
      stall_style = style;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) long_hold_req = 1'b1;
         offer_segment(random_segment(), 1'b0, '0);
         burst_left--;
         if (bursty && burst_left == 0) begin
            rest_sender($urandom_range(1, $urandom_range(0, 3) == 0 ? 70 : 10));
            burst_left = $urandom_range(1, 8);
         end
      end
      wait_drained();
   endtask

   // Receiver: long hold-off on request, otherwise the phase's stall style
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         case (stall_style)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               rsp_stall <= (pattern_phase < 3);
               pattern_phase = (pattern_phase + 1) % 7;
            end
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted pixel word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel word with nothing expected: x=%0d y=%0d",
                   rsp_data.pixel_x, rsp_data.pixel_y);
            mismatch_count++;
         end else begin
            expected_pixel = pending_pixels.pop_front();
            check_field("pixel_x", 32'(expected_pixel.pixel_x), 32'(rsp_data.pixel_x));
            check_field("pixel_y", 32'(expected_pixel.pixel_y), 32'(rsp_data.pixel_y));
            check_field("address", 32'(expected_pixel.address), 32'(rsp_data.address));
            check_field("pixel_value", 32'(expected_pixel.pixel_value),
                        32'(rsp_data.pixel_value));
            check_field("off_canvas", 32'(expected_pixel.off_canvas),
                        32'(rsp_data.off_canvas));
            check_field("last", 32'(expected_pixel.last), 32'(rsp_data.last));
         end
         pixels_checked++;
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      // Reset-canvas dots, then extremes, reversals and half-pixel rounding walks
      directed_rows.push_back(dot(0, 0, 450, 1'b0));
      directed_rows.push_back(dot(49, 9, 49, 1'b0));
      directed_rows.push_back(dot(49, 0, 499, 1'b0));
      directed_rows.push_back(dot(0, 9, 0, 1'b0));
      directed_rows.push_back(dot(63, 63, 0, 1'b1));
      directed_rows.push_back(dot(50, 5, 0, 1'b1));
      directed_rows.push_back(dot(10, 10, 0, 1'b1));
      directed_rows.push_back(walk(0, 0, 63, 0));
      directed_rows.push_back(walk(0, 0, 0, 63));
      directed_rows.push_back(walk(0, 0, 63, 63));
      directed_rows.push_back(walk(63, 63, 0, 0));
      directed_rows.push_back(walk(63, 0, 0, 63));
      directed_rows.push_back(walk(0, 0, 4, 2));
      directed_rows.push_back(walk(4, 2, 0, 0));
      directed_rows.push_back(walk(10, 40, 3, 0));
      directed_rows.push_back(walk(5, 5, 6, 5));
      directed_rows.push_back(walk(0, 63, 63, 62));
      directed_rows.push_back(walk(21, 42, 42, 21));
      directed_rows.push_back(walk(42, 21, 21, 42));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_segment(directed_rows[i].seg, directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      // Canvas sweeps: full size, single cell, zero width, saturation, masked bit 7, random, reset values
      apply_settings(8'd64, 8'd64, 8'hFF);
      run_segments(50, STALL_NONE, 1'b0, -1);
      apply_settings(8'd1, 8'd1, 8'h00);
      run_segments(50, STALL_RANDOM, 1'b1, -1);
      apply_settings(8'd0, 8'd37, 8'h55);
      run_segments(50, STALL_PATTERN, 1'b1, 5);
      apply_settings(8'd127, 8'd100, 8'hAA);
      run_segments(50, STALL_RANDOM, 1'b1, -1);
      apply_settings(8'h85, 8'hC0, 8'h0F);
      run_segments(50, STALL_PATTERN, 1'b1, -1);
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
      run_segments(50, STALL_RANDOM, 1'b1, 20);
      apply_settings(8'd50, 8'd10, 8'd111);
      run_segments(50, STALL_RANDOM, 1'b1, -1);

      repeat (END_PAUSE) @(posedge clock);
      $display("covered %0d segments, %0d pixel words checked, %0d canvas settings",
               segments_sent, pixels_checked, settings_applied);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
